@@ rtl/assert_macros.svh @@
// Assertion helpers, clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/qbd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package qbd_pkg;

  localparam int BLOCK_WEIGHTS = 32;

  localparam logic [2:0] FMT_HALF = 3'd0;
  localparam logic [2:0] FMT_Q4_0 = 3'd1;
  localparam logic [2:0] FMT_Q4_1 = 3'd2;
  localparam logic [2:0] FMT_Q5_0 = 3'd3;
  localparam logic [2:0] FMT_Q8_0 = 3'd4;

  localparam logic [5:0] LEN_HALF = 6'd2;
  localparam logic [5:0] LEN_Q4_0 = 6'd18;
  localparam logic [5:0] LEN_Q4_1 = 6'd20;
  localparam logic [5:0] LEN_Q5_0 = 6'd22;
  localparam logic [5:0] LEN_Q8_0 = 6'd34;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  typedef enum logic [1:0] {
    KIND_HALF = 2'd0,
    KIND_MUL  = 2'd1,
    KIND_SUM  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] scale;
    logic [15:0] offset;
    logic        k_neg;
    logic [7:0]  k_mag;
    logic [4:0]  idx;
    logic        run_end;
    logic        stream_end;
  } job_t;

  typedef struct packed {
    logic       we;
    logic [2:0] fmt;
  } cfg_wr_t;

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic       s;
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] p;
    logic [3:0] shifts;
    logic [9:0] mn;
    logic [7:0] e8;
    s   = h[15];
    ex  = h[14:10];
    man = h[9:0];
    p   = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) p = 4'(i);
    end
    shifts = 4'd10 - p;
    mn     = man << shifts;
    e8     = 8'd113 - {4'd0, shifts};
    if (ex == 5'd0) begin
      if (man == 10'd0) half_to_single = {s, 31'd0};
      else half_to_single = {s, e8, mn, 13'd0};
    end else if (ex == 5'd31) begin
      half_to_single = {s, 8'hFF, man, 13'd0};
    end else begin
      half_to_single = {s, 8'({3'd0, ex} + 8'd112), man, 13'd0};
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/qbd_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
module qbd_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire qbd_pkg::job_t din,
  output logic               full,
  input  wire logic          pop,
  output qbd_pkg::job_t      dout,
  output logic               empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qbd_pkg::job_t mem [DEPTH];
  logic [PW-1:0] rd_ptr, wr_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end
endmodule
`default_nettype wire

@@ rtl/qbd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module qbd_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire qbd_pkg::cfg_wr_t cfg,
  output logic [2:0]            fmt,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       data_byte,
  input  wire logic             last_byte,
  output logic                  push,
  output qbd_pkg::job_t         job,
  input  wire logic             q_full
);
  logic [5:0]  byte_position, byte_position_next;
  logic [15:0] scale_half, scale_half_next;
  logic [15:0] offset_half, offset_half_next;
  logic [31:0] high_bit_mask, high_bit_mask_next;
  logic [7:0]  held_low_byte, held_low_byte_next;
  logic [4:0]  half_weight_count, half_weight_count_next;

  qbd_pkg::job_t slot0, slot1, j0, j1;
  logic          slot0_v, slot1_v;
  logic [1:0]    n;
  logic          accept;

  logic [5:0] len, pos, pos_inc;
  logic [3:0] lo, hi, q;
  logic [1:0] sh;

  function automatic logic [8:0] to_sm(input logic signed [8:0] v);
    logic [8:0] a;
    a = v[8] ? 9'(-v) : 9'(v);
    to_sm = {v[8], a[7:0]};
  endfunction

  assign push     = slot0_v && !q_full;
  assign job      = slot0;
  assign in_ready = !slot0_v || (!slot1_v && push);
  assign accept   = in_valid && in_ready;

  assign lo = data_byte[3:0];
  assign hi = data_byte[7:4];

  always_comb begin
    unique case (fmt)
      qbd_pkg::FMT_HALF: len = qbd_pkg::LEN_HALF;
      qbd_pkg::FMT_Q4_0: len = qbd_pkg::LEN_Q4_0;
      qbd_pkg::FMT_Q4_1: len = qbd_pkg::LEN_Q4_1;
      qbd_pkg::FMT_Q5_0: len = qbd_pkg::LEN_Q5_0;
      qbd_pkg::FMT_Q8_0: len = qbd_pkg::LEN_Q8_0;
      default:           len = 6'd0;
    endcase
  end

  always_comb begin
    byte_position_next     = byte_position;
    scale_half_next        = scale_half;
    offset_half_next       = offset_half;
    high_bit_mask_next     = high_bit_mask;
    held_low_byte_next     = held_low_byte;
    half_weight_count_next = half_weight_count;
    n        = 2'd0;
    j0       = '0;
    j1       = '0;
    j0.scale = scale_half;
    j1.scale = scale_half;
    pos      = (byte_position >= len) ? 6'd0 : byte_position;
    pos_inc  = pos + 6'd1;
    q        = 4'(pos - 6'd6);
    sh       = 2'(pos - 6'd2);
    if (len != 6'd0) begin
      if (pos == 6'd0) begin
        held_low_byte_next = data_byte;
      end else if (fmt == qbd_pkg::FMT_HALF) begin
        j0.kind  = qbd_pkg::KIND_HALF;
        j0.scale = {data_byte, held_low_byte};
        j0.idx   = half_weight_count;
        n        = 2'd1;
        half_weight_count_next = half_weight_count + 5'd1;
      end else if (pos == 6'd1) begin
        scale_half_next = {data_byte, held_low_byte};
      end else begin
        unique case (fmt)
          qbd_pkg::FMT_Q4_0: begin
            j0.kind = qbd_pkg::KIND_MUL;
            j1.kind = qbd_pkg::KIND_MUL;
            {j0.k_neg, j0.k_mag} = to_sm(9'sd0 + $signed({5'd0, lo}) - 9'sd8);
            {j1.k_neg, j1.k_mag} = to_sm(9'sd0 + $signed({5'd0, hi}) - 9'sd8);
            j0.idx = 5'(pos - 6'd2);
            j1.idx = 5'(pos - 6'd2) + 5'd16;
            n = 2'd2;
          end
          qbd_pkg::FMT_Q4_1: begin
            if (pos == 6'd2) begin
              held_low_byte_next = data_byte;
            end else if (pos == 6'd3) begin
              offset_half_next = {data_byte, held_low_byte};
            end else begin
              j0.kind   = qbd_pkg::KIND_SUM;
              j1.kind   = qbd_pkg::KIND_SUM;
              j0.offset = offset_half;
              j1.offset = offset_half;
              j0.k_mag  = {4'd0, lo};
              j1.k_mag  = {4'd0, hi};
              j0.idx    = 5'(pos - 6'd4);
              j1.idx    = 5'(pos - 6'd4) + 5'd16;
              n = 2'd2;
            end
          end
          qbd_pkg::FMT_Q5_0: begin
            if (pos < 6'd6) begin
              high_bit_mask_next[{sh, 3'd0} +: 8] = data_byte;
            end else begin
              j0.kind = qbd_pkg::KIND_MUL;
              j1.kind = qbd_pkg::KIND_MUL;
              {j0.k_neg, j0.k_mag} =
                to_sm($signed({4'd0, high_bit_mask[{1'b0, q}], lo}) - 9'sd16);
              {j1.k_neg, j1.k_mag} =
                to_sm($signed({4'd0, high_bit_mask[{1'b1, q}], hi}) - 9'sd16);
              j0.idx = {1'b0, q};
              j1.idx = {1'b1, q};
              n = 2'd2;
            end
          end
          default: begin
            j0.kind = qbd_pkg::KIND_MUL;
            {j0.k_neg, j0.k_mag} = to_sm({data_byte[7], data_byte});
            j0.idx = 5'(pos - 6'd2);
            n = 2'd1;
          end
        endcase
      end
      byte_position_next = (pos_inc >= len) ? 6'd0 : pos_inc;
    end
    if (n == 2'd1) begin
      j0.run_end    = 1'b1;
      j0.stream_end = last_byte;
    end else if (n == 2'd2) begin
      j1.run_end    = 1'b1;
      j1.stream_end = last_byte;
    end
    if (last_byte) begin
      byte_position_next     = 6'd0;
      half_weight_count_next = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt               <= qbd_pkg::FMT_Q4_0;
      byte_position     <= '0;
      scale_half        <= '0;
      offset_half       <= '0;
      high_bit_mask     <= '0;
      held_low_byte     <= '0;
      half_weight_count <= '0;
      slot0_v           <= 1'b0;
      slot1_v           <= 1'b0;
    end else begin
      if (cfg.we) begin
        fmt               <= cfg.fmt;
        byte_position     <= '0;
        half_weight_count <= '0;
      end else if (accept) begin
        byte_position     <= byte_position_next;
        scale_half        <= scale_half_next;
        offset_half       <= offset_half_next;
        high_bit_mask     <= high_bit_mask_next;
        held_low_byte     <= held_low_byte_next;
        half_weight_count <= half_weight_count_next;
      end
      if (accept) begin
        slot0_v <= (n != 2'd0);
        slot1_v <= (n == 2'd2);
      end else if (push) begin
        slot0_v <= slot1_v;
        slot1_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot0 <= j0;
      slot1 <= j1;
    end else if (push) begin
      slot0 <= slot1;
    end
  end
endmodule
`default_nettype wire

@@ rtl/qbd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module qbd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire qbd_pkg::job_t job,
  input  wire logic          q_empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [31:0]        weight_bits,
  output logic [4:0]         element_index,
  output logic               run_end,
  output logic               stream_end
);
  typedef struct packed {
    logic [4:0] idx;
    logic       run_end;
    logic       stream_end;
    logic       special;
    logic [31:0] sbits;
    logic       sa;
    logic       sb;
  } tag_t;

  logic advance;
  logic v1, v2, v3, v4;

  // stage 1: decode, multiply, specials
  tag_t        t1;
  logic [18:0] prod1;
  logic [4:0]  ea1, eb1;
  logic [10:0] mb1;
  // stage 2: align
  tag_t        t2;
  logic [47:0] a2, b2;
  // stage 3: add
  tag_t        t3;
  logic [48:0] n3;
  logic        s3;
  // stage 4: coarse normalise
  tag_t        t4;
  logic [55:0] n4;
  logic [2:0]  g4;
  logic        s4;
  logic        z4;

  assign advance = !out_valid || out_ready;
  assign pop     = advance && !q_empty;

  // stage 1 logic
  logic        ss, sbo, s_inf, s_nan, b_inf, b_nan, a_nan, a_inf, sa_c;
  logic [10:0] ma, mbc;
  logic [4:0]  eac, ebc;
  tag_t        t1_c;
  always_comb begin
    ss    = job.scale[15];
    s_inf = (job.scale[14:10] == 5'd31) && (job.scale[9:0] == 10'd0);
    s_nan = (job.scale[14:10] == 5'd31) && (job.scale[9:0] != 10'd0);
    ma    = {job.scale[14:10] != 5'd0, job.scale[9:0]};
    eac   = (job.scale[14:10] == 5'd0) ? 5'd1 : job.scale[14:10];
    sbo   = job.offset[15];
    b_inf = (job.offset[14:10] == 5'd31) && (job.offset[9:0] == 10'd0);
    b_nan = (job.offset[14:10] == 5'd31) && (job.offset[9:0] != 10'd0);
    mbc   = {job.offset[14:10] != 5'd0, job.offset[9:0]};
    ebc   = (job.offset[14:10] == 5'd0) ? 5'd1 : job.offset[14:10];
    sa_c  = ss ^ job.k_neg;
    a_nan = s_nan || (s_inf && job.k_mag == 8'd0);
    a_inf = s_inf && job.k_mag != 8'd0;
    t1_c            = '0;
    t1_c.idx        = job.idx;
    t1_c.run_end    = job.run_end;
    t1_c.stream_end = job.stream_end;
    t1_c.sa         = sa_c;
    t1_c.sb         = sbo;
    unique case (job.kind)
      qbd_pkg::KIND_HALF: begin
        t1_c.special = 1'b1;
        t1_c.sbits   = qbd_pkg::half_to_single(job.scale);
      end
      qbd_pkg::KIND_SUM: begin
        if (a_nan || b_nan || (a_inf && b_inf && sa_c != sbo)) begin
          t1_c.special = 1'b1;
          t1_c.sbits   = qbd_pkg::CANON_NAN;
        end else if (a_inf) begin
          t1_c.special = 1'b1;
          t1_c.sbits   = {sa_c, 8'hFF, 23'd0};
        end else if (b_inf) begin
          t1_c.special = 1'b1;
          t1_c.sbits   = {sbo, 8'hFF, 23'd0};
        end
      end
      default: begin
        t1_c.sb = sa_c;
        if (a_nan) begin
          t1_c.special = 1'b1;
          t1_c.sbits   = qbd_pkg::CANON_NAN;
        end else if (a_inf) begin
          t1_c.special = 1'b1;
          t1_c.sbits   = {sa_c, 8'hFF, 23'd0};
        end
      end
    endcase
  end

  // stage 3 logic
  logic [48:0] n3_c;
  logic        s3_c;
  always_comb begin
    if (t2.sa == t2.sb) begin
      n3_c = {1'b0, a2} + {1'b0, b2};
      s3_c = t2.sa;
    end else if (a2 >= b2) begin
      n3_c = {1'b0, a2 - b2};
      s3_c = t2.sa;
    end else begin
      n3_c = {1'b0, b2 - a2};
      s3_c = t2.sb;
    end
    if (n3_c == 49'd0) s3_c = (t2.sa == t2.sb) ? t2.sa : 1'b0;
  end

  // stage 4 logic
  logic [55:0] w4;
  logic [2:0]  g4_c;
  always_comb begin
    w4   = {7'd0, n3};
    g4_c = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (w4[8*i +: 8] != 8'd0) g4_c = 3'(i);
    end
  end

  // stage 5 logic
  logic [2:0]  f5;
  logic [55:0] x5;
  logic [5:0]  l5;
  logic        rnd;
  logic [30:0] mag5;
  logic [31:0] res5;
  always_comb begin
    f5 = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (n4[48 + i]) f5 = 3'(i);
    end
    x5   = n4 << (3'd7 - f5);
    l5   = {g4, f5};
    rnd  = x5[31] && ((x5[30:0] != 31'd0) || x5[32]);
    mag5 = {8'({2'd0, l5} + 8'd103), x5[54:32]} + {30'd0, rnd};
    if (t4.special) res5 = t4.sbits;
    else if (z4) res5 = {s4, 31'd0};
    else res5 = {s4, mag5};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1 <= pop;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      t1    <= t1_c;
      prod1 <= 19'(ma * job.k_mag);
      ea1   <= eac;
      eb1   <= ebc;
      mb1   <= (job.kind == qbd_pkg::KIND_SUM) ? mbc : 11'd0;
      t2    <= t1;
      a2    <= {29'd0, prod1} << (ea1 - 5'd1);
      b2    <= {37'd0, mb1} << (eb1 - 5'd1);
      t3    <= t2;
      n3    <= n3_c;
      s3    <= s3_c;
      t4    <= t3;
      n4    <= w4 << {3'd6 - g4_c, 3'd0};
      g4    <= g4_c;
      s4    <= s3;
      z4    <= (n3 == 49'd0);
      weight_bits   <= res5;
      element_index <= t4.idx;
      run_end       <= t4.run_end;
      stream_end    <= t4.stream_end;
    end
  end
endmodule
`default_nettype wire

@@ rtl/quant_block_dequantizer_unit.sv @@
// Block dequantiser: packed weight blocks enter a byte per transfer and leave as
// single-precision weights, one per cycle while out_ready is high. A nibble byte
// of Q4_0, Q4_1 or Q5_0 gives two weights and holds off the input until the first
// has gone; a Q8_0 byte gives one, a half-precision pair one, a header byte none.
// The pipeline retires one weight per cycle while not stalled. Stages: front job
// register, queue, multiply, align, add, two normalise steps. fmt resets to Q4_0.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module quant_block_dequantizer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      weight_bits,
  output logic [4:0]       element_index,
  output logic             run_end,
  output logic             stream_end
);
  qbd_pkg::cfg_wr_t cfg;
  qbd_pkg::job_t    f_job, q_job;
  logic [2:0]       fmt;
  logic             push, q_full, q_empty, pop;

  assign pready  = 1'b1;
  assign cfg.we  = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign cfg.fmt = pwdata[2:0];
  assign prdata  = paddr[2] ? 32'd0 : {29'd0, fmt};

  qbd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .fmt       (fmt),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .push      (push),
    .job       (f_job),
    .q_full    (q_full)
  );

  qbd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (f_job),
    .full  (q_full),
    .pop   (pop),
    .dout  (q_job),
    .empty (q_empty)
  );

  qbd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job           (q_job),
    .q_empty       (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .weight_bits   (weight_bits),
    .element_index (element_index),
    .run_end       (run_end),
    .stream_end    (stream_end)
  );

  `ASSERT_CLK(a_no_push_full, push |-> !q_full, "queue written while full")
  `ASSERT_CLK(a_no_pop_empty, pop |-> !q_empty, "queue read while empty")
  `ASSERT_CLK(a_stream_end_run, (out_valid && stream_end) |-> run_end, "stream end off run end")
  `ASSERT_CLK_ALWAYS(a_pready, pready, "pready low")
endmodule
`default_nettype wire
